// ===== hdl/tmb_pkg.sv =====
package tmb_pkg;

  localparam int unsigned InstW   = 8;
  localparam int unsigned DayW    = 27;
  localparam int unsigned MinuteW = 11;
  localparam int unsigned PriceW  = 48;
  localparam int unsigned VolW    = 48;
  localparam int unsigned TurnW   = 56;
  localparam int unsigned OiW     = 40;

  localparam int unsigned TickW     = InstW + DayW + MinuteW + PriceW + VolW + TurnW + OiW;
  localparam int unsigned TickDataW = ((TickW + 7) / 8) * 8;
  localparam int unsigned BarW      = InstW + DayW + MinuteW + 4 * PriceW + VolW + TurnW + OiW;
  localparam int unsigned BarDataW  = ((BarW + 7) / 8) * 8;

  localparam logic [VolW-1:0] VolMax = {VolW{1'b1}};

  // Members are listed from the highest bit down, so the last member listed lands lowest.
  typedef struct packed {
    logic        [OiW-1:0]     interest;
    logic        [TurnW-1:0]   turnover;
    logic        [VolW-1:0]    run_volume;
    logic signed [PriceW-1:0]  price;
    logic        [MinuteW-1:0] minute_of_day;
    logic        [DayW-1:0]    tick_day;
    logic        [InstW-1:0]   instrument;
  } tick_t;

  typedef struct packed {
    logic        [OiW-1:0]     bar_interest;
    logic        [TurnW-1:0]   bar_turnover;
    logic        [VolW-1:0]    bar_volume;
    logic signed [PriceW-1:0]  close_price;
    logic signed [PriceW-1:0]  low_price;
    logic signed [PriceW-1:0]  high_price;
    logic signed [PriceW-1:0]  open_price;
    logic        [MinuteW-1:0] bar_minute;
    logic        [DayW-1:0]    bar_day;
    logic        [InstW-1:0]   bar_instrument;
  } bar_t;

  // One instrument's open bar as it sits in the bar memory.
  typedef struct packed {
    logic        [DayW-1:0]    open_day;
    logic        [MinuteW-1:0] open_minute;
    logic signed [PriceW-1:0]  open_value;
    logic signed [PriceW-1:0]  high_value;
    logic signed [PriceW-1:0]  low_value;
    logic signed [PriceW-1:0]  close_value;
    logic        [VolW-1:0]    volume_sum;
    logic        [TurnW-1:0]   turnover_value;
    logic        [OiW-1:0]     interest_value;
    logic        [VolW-1:0]    previous_cumulative;
  } entry_t;

  typedef struct packed {
    logic closes;
    logic opens;
  } upd_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

endpackage

// ===== hdl/tick_to_minute_bar_core.sv =====
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  one tick in s_axis_tdata_i
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  one closed bar in m_axis_tdata_o
//
// For each tick, the accept cycle issues the read of the instrument's bar from the
// simple dual-port bar memory, and the update state then merges and writes it back.
// A new tick is accepted only once the update state for the previous tick is done.
// Reset clears only the per-instrument valid flops, output valid and control state; no memory pass.
// A closing tick waits in the update cycle while the previous bar is still held in the
// output register and not taken; the output register otherwise lets intake continue.
module tick_to_minute_bar_core #(
  parameter int unsigned INSTRUMENTS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // instrument, tick_day, minute_of_day, price, run_volume, turnover,
  // interest, then zero fill
  input  logic [tmb_pkg::TickDataW-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // bar_instrument, bar_day, bar_minute, open_price, high_price, low_price,
  // close_price, bar_volume, bar_turnover, bar_interest, then zero fill
  output logic [tmb_pkg::BarDataW-1:0]   m_axis_tdata_o
);
  import tmb_pkg::*;

  localparam int unsigned DEPTH  = (INSTRUMENTS > 256) ? 256 : INSTRUMENTS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [16:0] InstLimit = 17'(INSTRUMENTS);

  state_e          state_q, state_d;
  tick_t           tick_q;
  tick_t           tick_in;
  logic [DEPTH-1:0] valid_q;
  logic            s_accept;
  logic            in_range;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] idx;
  entry_t          rd_entry;
  entry_t          wr_entry;
  bar_t            bar;
  bar_t            bar_q;
  upd_status_t     status;
  logic            entry_valid;
  logic            out_free;
  logic            mem_we;
  logic            out_load;
  logic            m_tvalid_q;

  assign tick_in  = tick_t'(s_axis_tdata_i[TickW-1:0]);
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_addr  = tick_in.instrument[ADDR_W-1:0];
  assign idx      = tick_q.instrument[ADDR_W-1:0];
  assign in_range = {9'd0, tick_q.instrument} < InstLimit;
  assign entry_valid = in_range && valid_q[idx];
  assign out_free = !m_tvalid_q || m_axis_tready_i;

  tmb_bar_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (s_accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry),
    .wr_en_i   (mem_we),
    .wr_addr_i (idx),
    .wr_data_i (wr_entry)
  );

  tmb_bar_update u_update (
    .tick_i        (tick_q),
    .entry_i       (rd_entry),
    .entry_valid_i (entry_valid),
    .entry_o       (wr_entry),
    .bar_o         (bar),
    .status_o      (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    mem_we          = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!in_range) begin
          state_d = ST_IDLE;
        end else if (!status.closes || out_free) begin
          mem_we   = 1'b1;
          out_load = status.closes;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      tick_q <= tick_in;
    end
    if (out_load) begin
      bar_q <= bar;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[idx] <= 1'b1;
      end
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = {{(BarDataW - BarW){1'b0}}, bar_q};

  a_write_in_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_UPDATE) && in_range)
    else $error("bar memory written outside the update cycle");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("closed bar overwrote an untaken result");

  a_accept_then_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == ST_UPDATE))
    else $error("accepted tick did not reach the update cycle");

  a_close_needs_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> entry_valid)
    else $error("bar emitted for an instrument with no open bar");

endmodule

// ===== hdl/tmb_bar_mem.sv =====
module tmb_bar_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [ADDR_W-1:0]   rd_addr_i,
  output tmb_pkg::entry_t     rd_data_o,
  input  logic                wr_en_i,
  input  logic [ADDR_W-1:0]   wr_addr_i,
  input  tmb_pkg::entry_t     wr_data_i
);
  import tmb_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/tmb_bar_update.sv =====
module tmb_bar_update (
  input  tmb_pkg::tick_t       tick_i,
  input  tmb_pkg::entry_t      entry_i,
  input  logic                 entry_valid_i,
  output tmb_pkg::entry_t      entry_o,
  output tmb_pkg::bar_t        bar_o,
  output tmb_pkg::upd_status_t status_o
);
  import tmb_pkg::*;

  entry_t          fresh;
  entry_t          merged;
  logic            key_differs;
  logic [VolW-1:0] delta;
  logic [VolW:0]   sum;

  assign key_differs = (entry_i.open_day != tick_i.tick_day) ||
                       (entry_i.open_minute != tick_i.minute_of_day);

  assign status_o.opens  = !entry_valid_i || key_differs;
  assign status_o.closes = entry_valid_i && key_differs;

  always_comb begin
    fresh.open_day            = tick_i.tick_day;
    fresh.open_minute         = tick_i.minute_of_day;
    fresh.open_value          = tick_i.price;
    fresh.high_value          = tick_i.price;
    fresh.low_value           = tick_i.price;
    fresh.close_value         = tick_i.price;
    fresh.volume_sum          = '0;
    fresh.turnover_value      = tick_i.turnover;
    fresh.interest_value      = tick_i.interest;
    fresh.previous_cumulative = tick_i.run_volume;
  end

  // A carry out of the sum means the delta did not fit in the remaining room.
  assign delta = tick_i.run_volume - entry_i.previous_cumulative;
  assign sum   = {1'b0, entry_i.volume_sum} + {1'b0, delta};

  always_comb begin
    merged             = entry_i;
    merged.close_value = tick_i.price;
    if (tick_i.price > entry_i.high_value) begin
      merged.high_value = tick_i.price;
    end
    if (tick_i.price < entry_i.low_value) begin
      merged.low_value = tick_i.price;
    end
    merged.turnover_value      = tick_i.turnover;
    merged.interest_value      = tick_i.interest;
    merged.previous_cumulative = tick_i.run_volume;
    if (tick_i.run_volume >= entry_i.previous_cumulative) begin
      merged.volume_sum = sum[VolW] ? VolMax : sum[VolW-1:0];
    end
  end

  assign entry_o = status_o.opens ? fresh : merged;

  always_comb begin
    bar_o.bar_instrument = tick_i.instrument;
    bar_o.bar_day        = entry_i.open_day;
    bar_o.bar_minute     = entry_i.open_minute;
    bar_o.open_price     = entry_i.open_value;
    bar_o.high_price     = entry_i.high_value;
    bar_o.low_price      = entry_i.low_value;
    bar_o.close_price    = entry_i.close_value;
    bar_o.bar_volume     = entry_i.volume_sum;
    bar_o.bar_turnover   = entry_i.turnover_value;
    bar_o.bar_interest   = entry_i.interest_value;
  end

endmodule
